// ===== hdl/aarm_pkg.sv =====
package aarm_pkg;

  localparam int FracBits    = 14;
  localparam int CordicSteps = 30;
  localparam int ThW         = 34;
  localparam int CxW         = 33;
  localparam int CW          = 18;
  localparam int TensW       = 20;
  localparam int SinW        = 18;
  localparam int SumW        = 21;
  localparam int RndC        = 30 - FracBits;

  localparam logic signed [CxW-1:0] CordicGain = CxW'(64'h26DD3B6A);
  localparam logic signed [ThW-1:0] PiQ30      = ThW'(64'hC90FDAA2);
  localparam logic signed [ThW-1:0] HalfPiQ30  = ThW'(64'h6487ED51);

  typedef logic signed [15:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } axis_t;

  typedef struct packed {
    word_t r00;
    word_t r01;
    word_t r02;
    word_t r10;
    word_t r11;
    word_t r12;
    word_t r20;
    word_t r21;
    word_t r22;
  } mat_t;

  function automatic logic signed [ThW-1:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;
      1: v = 32'h1DAC6705;
      2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;
      4: v = 32'h03FEAB76;
      5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;
      7: v = 32'h007FFF55;
      8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000007;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return ThW'(v);
  endfunction

  function automatic word_t sat16(input logic signed [SumW-1:0] v);
    if (v > SumW'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -SumW'(32768)) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ===== hdl/aarm_cordic.sv =====
module aarm_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  aarm_pkg::word_t                       angle,
  input  aarm_pkg::axis_t                       in_axis,
  output logic                                  out_valid,
  output logic signed [aarm_pkg::CW-1:0]        c,
  output logic signed [aarm_pkg::CW-1:0]        s,
  output aarm_pkg::axis_t                       out_axis
);

  localparam int N = aarm_pkg::CordicSteps;

  logic                                 vld [N+1];
  logic signed [aarm_pkg::ThW-1:0]      th  [N+1];
  logic signed [aarm_pkg::CxW-1:0]      cx  [N+1];
  logic signed [aarm_pkg::CxW-1:0]      cy  [N+1];
  logic                                 neg [N+1];
  aarm_pkg::axis_t                      ax  [N+1];

  logic signed [aarm_pkg::ThW-1:0] th_in;
  logic signed [aarm_pkg::CxW-1:0] cx_fin;
  logic signed [aarm_pkg::CxW-1:0] cy_fin;
  logic signed [aarm_pkg::CxW-1:0] cx_rnd;
  logic signed [aarm_pkg::CxW-1:0] cy_rnd;

  // range reduction to within +-pi/2
  assign th_in = {{(aarm_pkg::ThW-33){angle[15]}}, angle, 17'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= aarm_pkg::CordicGain;
      cy[0] <= '0;
      ax[0] <= in_axis;
      if (th_in > aarm_pkg::HalfPiQ30) begin
        th[0]  <= th_in - aarm_pkg::PiQ30;
        neg[0] <= 1'b1;
      end else if (th_in < -aarm_pkg::HalfPiQ30) begin
        th[0]  <= th_in + aarm_pkg::PiQ30;
        neg[0] <= 1'b1;
      end else begin
        th[0]  <= th_in;
        neg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        ax[i+1]  <= ax[i];
        if (th[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          th[i+1] <= th[i] - aarm_pkg::atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          th[i+1] <= th[i] + aarm_pkg::atan_q30(i);
        end
      end
    end
  end

  // undo reduction, round to output fraction
  assign cx_fin = neg[N] ? -cx[N] : cx[N];
  assign cy_fin = neg[N] ? -cy[N] : cy[N];
  assign cx_rnd = (cx_fin + (aarm_pkg::CxW'(1) <<< (aarm_pkg::RndC - 1))) >>> aarm_pkg::RndC;
  assign cy_rnd = (cy_fin + (aarm_pkg::CxW'(1) <<< (aarm_pkg::RndC - 1))) >>> aarm_pkg::RndC;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c        <= cx_rnd[aarm_pkg::CW-1:0];
      s        <= cy_rnd[aarm_pkg::CW-1:0];
      out_axis <= ax[N];
    end
  end

endmodule

// ===== hdl/aarm_matrix.sv =====
module aarm_matrix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [aarm_pkg::CW-1:0] c,
  input  logic signed [aarm_pkg::CW-1:0] s,
  input  aarm_pkg::axis_t                axis,
  output logic                           out_valid,
  output aarm_pkg::mat_t                 mat
);

  localparam int F  = aarm_pkg::FracBits;
  localparam int F2 = 2 * aarm_pkg::FracBits;
  localparam int PW = 50;

  logic                            va, vb;
  logic signed [aarm_pkg::CW-1:0]  ca, ta, cb;
  logic signed [31:0]              xx, yy, zz, xy, xz, yz;
  logic signed [33:0]              sxp, syp, szp;
  logic signed [aarm_pkg::TensW-1:0] txx, tyy, tzz, txy, txz, tyz;
  logic signed [aarm_pkg::SinW-1:0]  sx, sy, sz;
  logic signed [aarm_pkg::SumW-1:0]  cbw;

  function automatic logic signed [aarm_pkg::TensW-1:0] tens(
    input logic signed [aarm_pkg::CW-1:0] t,
    input logic signed [31:0] uv
  );
    logic signed [PW-1:0] p;
    p = (PW'(t) * PW'(uv) + (PW'(1) <<< (F2 - 1))) >>> F2;
    return p[aarm_pkg::TensW-1:0];
  endfunction

  function automatic logic signed [aarm_pkg::SinW-1:0] sin_rnd(
    input logic signed [33:0] p
  );
    logic signed [33:0] r;
    r = (p + (34'sd1 <<< (F - 1))) >>> F;
    return r[aarm_pkg::SinW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  // axis products and sine products
  always_ff @(posedge clk) begin
    if (en) begin
      ca  <= c;
      ta  <= (aarm_pkg::CW'(1) <<< F) - c;
      xx  <= axis.x * axis.x;
      yy  <= axis.y * axis.y;
      zz  <= axis.z * axis.z;
      xy  <= axis.x * axis.y;
      xz  <= axis.x * axis.z;
      yz  <= axis.y * axis.z;
      sxp <= 34'(s) * 34'(axis.x);
      syp <= 34'(s) * 34'(axis.y);
      szp <= 34'(s) * 34'(axis.z);
    end
  end

  // tensor terms, round
  always_ff @(posedge clk) begin
    if (en) begin
      cb  <= ca;
      txx <= tens(ta, xx);
      tyy <= tens(ta, yy);
      tzz <= tens(ta, zz);
      txy <= tens(ta, xy);
      txz <= tens(ta, xz);
      tyz <= tens(ta, yz);
      sx  <= sin_rnd(sxp);
      sy  <= sin_rnd(syp);
      sz  <= sin_rnd(szp);
    end
  end

  assign cbw = aarm_pkg::SumW'(cb);

  always_ff @(posedge clk) begin
    if (en) begin
      mat.r00 <= aarm_pkg::sat16(cbw + aarm_pkg::SumW'(txx));
      mat.r01 <= aarm_pkg::sat16(aarm_pkg::SumW'(txy) + aarm_pkg::SumW'(sz));
      mat.r02 <= aarm_pkg::sat16(aarm_pkg::SumW'(txz) - aarm_pkg::SumW'(sy));
      mat.r10 <= aarm_pkg::sat16(aarm_pkg::SumW'(txy) - aarm_pkg::SumW'(sz));
      mat.r11 <= aarm_pkg::sat16(cbw + aarm_pkg::SumW'(tyy));
      mat.r12 <= aarm_pkg::sat16(aarm_pkg::SumW'(tyz) + aarm_pkg::SumW'(sx));
      mat.r20 <= aarm_pkg::sat16(aarm_pkg::SumW'(txz) + aarm_pkg::SumW'(sy));
      mat.r21 <= aarm_pkg::sat16(aarm_pkg::SumW'(tyz) - aarm_pkg::SumW'(sx));
      mat.r22 <= aarm_pkg::sat16(cbw + aarm_pkg::SumW'(tzz));
    end
  end

endmodule

// ===== hdl/axis_angle_rotation_matrix_core.sv =====
// Axis-angle to 3x3 rotation matrix. One beat in (Q2.13 angle, Q1.14 axis),
// one beat out (nine Q1.14 elements, saturated). Accepts a beat every cycle
// while the output is not stalled; the pipeline is one range-reduction stage,
// 30 CORDIC iteration stages, one rounding stage, then three matrix stages
// (products, tensor products with rounding, sums with saturation). The whole
// pipeline holds while the output beat waits for m_tready.
module axis_angle_rotation_matrix_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // angle, axis_x, axis_y, axis_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata    // r00, r01, r02, r10, r11, r12, r20, r21, r22
);

  logic                           en;
  logic                           cv;
  logic signed [aarm_pkg::CW-1:0] c, s;
  aarm_pkg::axis_t                ax_in, ax_c;
  aarm_pkg::mat_t                 mat;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign ax_in.x = s_tdata[31:16];
  assign ax_in.y = s_tdata[47:32];
  assign ax_in.z = s_tdata[63:48];

  aarm_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .angle     (s_tdata[15:0]),
    .in_axis   (ax_in),
    .out_valid (cv),
    .c         (c),
    .s         (s),
    .out_axis  (ax_c)
  );

  aarm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv),
    .c         (c),
    .s         (s),
    .axis      (ax_c),
    .out_valid (m_tvalid),
    .mat       (mat)
  );

  assign m_tdata = {mat.r22, mat.r21, mat.r20, mat.r12, mat.r11, mat.r10,
                    mat.r02, mat.r01, mat.r00};

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_diag_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(mat))
    else $error("matrix changed while stalled");
`endif

endmodule

// ===== tb/aarm_checker.sv =====
module aarm_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [143:0] m_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint GainQ30   = 64'h26DD3B6A;
  localparam longint PiQ30L    = 64'hC90FDAA2;
  localparam longint HalfPiQ30 = 64'h6487ED51;

  logic [143:0] matrix_q[$];
  longint atan_tab[30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [143:0] rotation_matrix(logic [63:0] beat);
    longint a, x, y, z, th, cx, cy, nx, c, s, t;
    longint txx, tyy, tzz, txy, txz, tyz, sx, sy, sz;
    bit flip;
    logic [143:0] m;
    a = longint'($signed(beat[15:0]));
    x = longint'($signed(beat[31:16]));
    y = longint'($signed(beat[47:32]));
    z = longint'($signed(beat[63:48]));
    th = a * 131072;
    flip = 0;
    if (th > HalfPiQ30) begin
      th -= PiQ30L; flip = 1;
    end else if (th < -HalfPiQ30) begin
      th += PiQ30L; flip = 1;
    end
    cx = GainQ30;
    cy = 0;
    for (int i = 0; i < 30; i++) begin
      if (th >= 0) begin
        nx = cx - (cy >>> i); cy = cy + (cx >>> i); th -= atan_tab[i];
      end else begin
        nx = cx + (cy >>> i); cy = cy - (cx >>> i); th += atan_tab[i];
      end
      cx = nx;
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    c = round_shift(cx, 16);
    s = round_shift(cy, 16);
    t = 16384 - c;
    txx = round_shift(t * (x * x), 28);
    tyy = round_shift(t * (y * y), 28);
    tzz = round_shift(t * (z * z), 28);
    txy = round_shift(t * (x * y), 28);
    txz = round_shift(t * (x * z), 28);
    tyz = round_shift(t * (y * z), 28);
    sx = round_shift(s * x, 14);
    sy = round_shift(s * y, 14);
    sz = round_shift(s * z, 14);
    m[15:0]    = clip16(c + txx);
    m[31:16]   = clip16(txy + sz);
    m[47:32]   = clip16(txz - sy);
    m[63:48]   = clip16(txy - sz);
    m[79:64]   = clip16(c + tyy);
    m[95:80]   = clip16(tyz + sx);
    m[111:96]  = clip16(txz + sy);
    m[127:112] = clip16(tyz - sx);
    m[143:128] = clip16(c + tzz);
    return m;
  endfunction

  initial fail_count = 0;
  assign pending = matrix_q.size();

  always @(posedge clk) begin
    logic [143:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) matrix_q.push_back(rotation_matrix(s_tdata));
      if (m_tvalid && m_tready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = matrix_q.pop_front();
          for (int e = 0; e < 9; e++) begin
            if (want[e*16 +: 16] !== m_tdata[e*16 +: 16]) begin
              $display("%0t: element %0d expected %0d, got %0d", $time, e,
                       $signed(want[e*16 +: 16]), $signed(m_tdata[e*16 +: 16]));
              fail_count++;
            end
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_axis_angle_rotation_matrix_core.sv =====
module tb_axis_angle_rotation_matrix_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;
  int           fail_count;
  int           pending;
  bit           calm;
  bit           hold_out;

  axis_angle_rotation_matrix_core i_dut (.*);

  aarm_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] unit_axis_beat(logic [15:0] ang);
    case ($urandom_range(0, 5))
      0: return {16'h0000, 16'h0000, 16'h4000, ang};
      1: return {16'h0000, 16'h4000, 16'h0000, ang};
      2: return {16'h4000, 16'h0000, 16'h0000, ang};
      3: return {16'h24F3, 16'hDB0D, 16'h24F3, ang};
      4: return {16'hC000, 16'h0000, 16'h0000, ang};
      default: return {16'h2D41, 16'h0000, 16'hD2BF, ang};
    endcase
  endfunction

  task automatic send_beat(logic [63:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst || calm || hold_out) begin
      m_tready <= !hold_out;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    logic [15:0] ang_edges[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h3244,
                                  16'hCDBC, 16'h6488, 16'h9B78, 16'h0001};
    int waited;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    m_tready = 0;
    calm = 0;
    hold_out = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (ang_edges[i]) send_beat(unit_axis_beat(ang_edges[i]));
    send_beat({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h6488});
    send_beat({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_beat({16'h8000, 16'h7FFF, 16'h8000, 16'h3244});
    send_beat({16'h7FFF, 16'h8000, 16'h0000, 16'hCDBC});
    send_beat({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_beat('0);
    hold_out = 1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_out = 0;
      end
    join_none
    for (int i = 0; i < 60; i++) send_beat(unit_axis_beat(16'($urandom)));
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (hold_out || pending != 0) @(posedge clk);
    for (int i = 0; i < 1750; i++) begin
      if (i == 1500) calm = 1;
      if (i == 800) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 3) != 0) send_beat(unit_axis_beat(16'($urandom)));
      else send_beat({pick_word(), pick_word(), pick_word(), pick_word()});
    end
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/aarm_pkg.sv
hdl/aarm_cordic.sv
hdl/aarm_matrix.sv
hdl/axis_angle_rotation_matrix_core.sv
tb/aarm_checker.sv
tb/tb_axis_angle_rotation_matrix_core.sv
